### hdl/aabb_pkg.sv
// Opcode and face codes shared by the box point push-out unit.
package aabb_pkg;

  typedef enum logic [1:0] {
    OP_FACE   = 2'd0,
    OP_EXTENT = 2'd1,
    OP_OFFSET = 2'd2,
    OP_SCALED = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    FACE_XMIN = 3'd0,
    FACE_XMAX = 3'd1,
    FACE_YMIN = 3'd2,
    FACE_YMAX = 3'd3,
    FACE_ZMIN = 3'd4,
    FACE_ZMAX = 3'd5
  } face_e;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned PipeLatency = 6;

endpackage

### hdl/aabb_point_pushout_unit.sv
// Top level of the box point push-out unit: six-stage pipeline.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   query   | start_i / busy_o   | opcode_i, point_*_i, box_min_*_i,
//           |                    | box_max_*_i, push_offset_i
//   result  | done_o (strobe)    | new_*_o, was_inside_o, face_chosen_o,
//           |                    | saturated_o
//
// One item enters per cycle; busy_o stays low, so the pipeline never holds off.
// Each result leaves the stage F registers and is shown for one cycle.
// Stages: bounds and distances, per-axis face, axis choice, partial products,
// product sum and offset, add and clip. The multiplier sets the depth.
// Reset clears the stage valid bits; items in flight are dropped.
module aabb_point_pushout_unit
  import aabb_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_z_i,
  input  logic signed [COORD_WIDTH-1:0] push_offset_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] new_x_o,
  output logic signed [COORD_WIDTH-1:0] new_y_o,
  output logic signed [COORD_WIDTH-1:0] new_z_o,
  output logic                          was_inside_o,
  output logic [2:0]                    face_chosen_o,
  output logic                          saturated_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned HW = (CW + 1) / 2;
  localparam int unsigned PW = 4 * HW;
  localparam int unsigned DW = CW + 2;
  localparam int unsigned RW = CW + 3;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Stage A: inside test and face distances.
  logic signed [CW-1:0] pin [NumAxes];
  logic signed [CW-1:0] mnin [NumAxes];
  logic signed [CW-1:0] mxin [NumAxes];
  logic                 in_a_d;
  logic [CW-1:0]        dlo_a_d [NumAxes];
  logic [CW-1:0]        dhi_a_d [NumAxes];

  logic                 va_q;
  op_e                  op_a_q;
  logic                 in_a_q;
  logic signed [CW-1:0] p_a_q [NumAxes];
  logic signed [CW-1:0] mn_a_q [NumAxes];
  logic signed [CW-1:0] mx_a_q [NumAxes];
  logic signed [CW-1:0] off_a_q;
  logic [CW-1:0]        dlo_a_q [NumAxes];
  logic [CW-1:0]        dhi_a_q [NumAxes];

  assign pin[0]  = point_x_i;
  assign pin[1]  = point_y_i;
  assign pin[2]  = point_z_i;
  assign mnin[0] = box_min_x_i;
  assign mnin[1] = box_min_y_i;
  assign mnin[2] = box_min_z_i;
  assign mxin[0] = box_max_x_i;
  assign mxin[1] = box_max_y_i;
  assign mxin[2] = box_max_z_i;

  always_comb begin
    in_a_d = 1'b1;
    for (int a = 0; a < NumAxes; a++) begin
      if (pin[a] < mnin[a] || pin[a] > mxin[a]) begin
        in_a_d = 1'b0;
      end
      dlo_a_d[a] = pin[a] - mnin[a];
      dhi_a_d[a] = mxin[a] - pin[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    op_a_q  <= op_e'(opcode_i);
    in_a_q  <= in_a_d;
    off_a_q <= push_offset_i;
    for (int a = 0; a < NumAxes; a++) begin
      p_a_q[a]   <= pin[a];
      mn_a_q[a]  <= mnin[a];
      mx_a_q[a]  <= mxin[a];
      dlo_a_q[a] <= dlo_a_d[a];
      dhi_a_q[a] <= dhi_a_d[a];
    end
  end

  // Stage B: nearer face per axis, extents, offset magnitude.
  logic                 vb_q;
  op_e                  op_b_q;
  logic                 in_b_q;
  logic signed [CW-1:0] p_b_q [NumAxes];
  logic signed [CW-1:0] off_b_q;
  logic [CW-1:0]        offmag_b_q;
  logic                 offneg_b_q;
  logic                 side_b_q [NumAxes];
  logic [CW-1:0]        dmin_b_q [NumAxes];
  logic signed [CW-1:0] fval_b_q [NumAxes];
  logic [CW-1:0]        ext_b_q [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op_b_q     <= op_a_q;
    in_b_q     <= in_a_q;
    off_b_q    <= off_a_q;
    offneg_b_q <= off_a_q[CW-1];
    offmag_b_q <= off_a_q[CW-1] ? CW'(-off_a_q) : CW'(off_a_q);
    for (int a = 0; a < NumAxes; a++) begin
      p_b_q[a]    <= p_a_q[a];
      side_b_q[a] <= dhi_a_q[a] < dlo_a_q[a];
      dmin_b_q[a] <= (dhi_a_q[a] < dlo_a_q[a]) ? dhi_a_q[a] : dlo_a_q[a];
      fval_b_q[a] <= (dhi_a_q[a] < dlo_a_q[a]) ? mx_a_q[a] : mn_a_q[a];
      ext_b_q[a]  <= mx_a_q[a] - mn_a_q[a];
    end
  end

  // Stage C: axis choice; y is skipped in the x/z modes.
  logic       xz_b;
  logic [1:0] ax_c_d;

  assign xz_b = (op_b_q == OP_EXTENT) || (op_b_q == OP_SCALED);

  always_comb begin
    logic [CW-1:0] dbest;
    ax_c_d = 2'd0;
    dbest  = dmin_b_q[0];
    if (!xz_b && dmin_b_q[1] < dbest) begin
      ax_c_d = 2'd1;
      dbest  = dmin_b_q[1];
    end
    if (dmin_b_q[2] < dbest) begin
      ax_c_d = 2'd2;
    end
  end

  logic                 vc_q;
  op_e                  op_c_q;
  logic                 in_c_q;
  logic signed [CW-1:0] p_c_q [NumAxes];
  logic signed [CW-1:0] off_c_q;
  logic [CW-1:0]        offmag_c_q;
  logic                 offneg_c_q;
  logic [1:0]           ax_c_q;
  logic                 side_c_q;
  logic signed [CW-1:0] fval_c_q;
  logic [CW-1:0]        ext_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op_c_q     <= op_b_q;
    in_c_q     <= in_b_q;
    off_c_q    <= off_b_q;
    offmag_c_q <= offmag_b_q;
    offneg_c_q <= offneg_b_q;
    ax_c_q     <= ax_c_d;
    side_c_q   <= side_b_q[ax_c_d];
    fval_c_q   <= fval_b_q[ax_c_d];
    ext_c_q    <= ext_b_q[ax_c_d];
    for (int a = 0; a < NumAxes; a++) begin
      p_c_q[a] <= p_b_q[a];
    end
  end

  // Stage D: half-width partial products of extent and offset magnitude.
  logic [2*HW-1:0] ea;
  logic [2*HW-1:0] ob;

  assign ea = (2 * HW)'(ext_c_q);
  assign ob = (2 * HW)'(offmag_c_q);

  logic                 vd_q;
  op_e                  op_d_q;
  logic                 in_d_q;
  logic signed [CW-1:0] p_d_q [NumAxes];
  logic signed [CW-1:0] off_d_q;
  logic                 offneg_d_q;
  logic [1:0]           ax_d_q;
  logic                 side_d_q;
  logic signed [CW-1:0] fval_d_q;
  logic [CW-1:0]        ext_d_q;
  logic [2*HW-1:0]      pp_ll_q;
  logic [2*HW-1:0]      pp_lh_q;
  logic [2*HW-1:0]      pp_hl_q;
  logic [2*HW-1:0]      pp_hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_q     <= op_c_q;
    in_d_q     <= in_c_q;
    off_d_q    <= off_c_q;
    offneg_d_q <= offneg_c_q;
    ax_d_q     <= ax_c_q;
    side_d_q   <= side_c_q;
    fval_d_q   <= fval_c_q;
    ext_d_q    <= ext_c_q;
    pp_ll_q    <= (2 * HW)'(ea[HW-1:0]) * (2 * HW)'(ob[HW-1:0]);
    pp_lh_q    <= (2 * HW)'(ea[HW-1:0]) * (2 * HW)'(ob[2*HW-1:HW]);
    pp_hl_q    <= (2 * HW)'(ea[2*HW-1:HW]) * (2 * HW)'(ob[HW-1:0]);
    pp_hh_q    <= (2 * HW)'(ea[2*HW-1:HW]) * (2 * HW)'(ob[2*HW-1:HW]);
    for (int a = 0; a < NumAxes; a++) begin
      p_d_q[a] <= p_c_q[a];
    end
  end

  // Stage E: product sum, fraction shift, cap, offset per mode.
  logic [PW-1:0]        prod;
  logic [PW-1:0]        scaled;
  logic [CW:0]          mag;
  logic signed [DW-1:0] delta_d;

  assign prod = PW'(pp_ll_q)
              + ((PW'(pp_lh_q) + PW'(pp_hl_q)) << HW)
              + (PW'(pp_hh_q) << (2 * HW));
  assign scaled = prod >> FRAC_BITS;
  assign mag = (|scaled[PW-1:CW]) ? ((CW + 1)'(1) << CW) : {1'b0, scaled[CW-1:0]};

  always_comb begin
    unique case (op_d_q)
      OP_FACE:   delta_d = '0;
      OP_EXTENT: delta_d = DW'(ext_d_q);
      OP_OFFSET: delta_d = DW'(off_d_q);
      OP_SCALED: delta_d = offneg_d_q ? -$signed(DW'(mag)) : $signed(DW'(mag));
      default:   delta_d = '0;
    endcase
  end

  logic                 ve_q;
  logic                 in_e_q;
  logic signed [CW-1:0] p_e_q [NumAxes];
  logic [1:0]           ax_e_q;
  logic                 side_e_q;
  logic signed [CW-1:0] fval_e_q;
  logic signed [DW-1:0] delta_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_e_q    <= in_d_q;
    ax_e_q    <= ax_d_q;
    side_e_q  <= side_d_q;
    fval_e_q  <= fval_d_q;
    delta_e_q <= delta_d;
    for (int a = 0; a < NumAxes; a++) begin
      p_e_q[a] <= p_d_q[a];
    end
  end

  // Stage F: move the chosen coordinate and clip it.
  logic signed [RW-1:0] res;
  logic                 ovf;
  logic signed [CW-1:0] moved;
  logic signed [CW-1:0] coord_d [NumAxes];

  assign res = side_e_q ? (RW'(fval_e_q) + RW'(delta_e_q))
                        : (RW'(fval_e_q) - RW'(delta_e_q));
  assign ovf = !((&res[RW-1:CW-1]) || !(|res[RW-1:CW-1]));

  always_comb begin
    if (!ovf) begin
      moved = res[CW-1:0];
    end else if (res[RW-1]) begin
      moved = {1'b1, {(CW - 1){1'b0}}};
    end else begin
      moved = {1'b0, {(CW - 1){1'b1}}};
    end
    for (int a = 0; a < NumAxes; a++) begin
      coord_d[a] = (in_e_q && ax_e_q == 2'(a)) ? moved : p_e_q[a];
    end
  end

  logic                 done_q;
  logic signed [CW-1:0] new_x_q;
  logic signed [CW-1:0] new_y_q;
  logic signed [CW-1:0] new_z_q;
  logic                 was_inside_q;
  face_e                face_q;
  logic                 sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    new_x_q      <= coord_d[0];
    new_y_q      <= coord_d[1];
    new_z_q      <= coord_d[2];
    was_inside_q <= in_e_q;
    face_q       <= in_e_q ? face_e'({ax_e_q, side_e_q}) : FACE_XMIN;
    sat_q        <= in_e_q & ovf;
  end

  assign done_o        = done_q;
  assign new_x_o       = new_x_q;
  assign new_y_o       = new_y_q;
  assign new_z_o       = new_z_q;
  assign was_inside_o  = was_inside_q;
  assign face_chosen_o = face_q;
  assign saturated_o   = sat_q;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PipeLatency done_o)
    else $error("result strobe missing after an accepted item");

  a_outside_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !was_inside_o) |-> (face_chosen_o == FACE_XMIN && !saturated_o))
    else $error("outside point reports a face or clipping");

  a_face_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && was_inside_o) |-> (face_chosen_o <= FACE_ZMAX))
    else $error("face code out of range");

  a_xz_axis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vc_q && in_c_q && (op_c_q == OP_EXTENT || op_c_q == OP_SCALED))
      |-> (ax_c_q != 2'd1))
    else $error("y face chosen in an x/z mode");
`endif

endmodule

### dv/tb_aabb_point_pushout_unit.sv
// Testbench for the box point push-out unit: directed table, random queries, self-checking.
module tb_aabb_point_pushout_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;
  localparam int          RandomItems = 600;
  localparam int          CycleLimit  = 200000;

  localparam logic [CoordWidth-1:0] One  = 32'h0001_0000;
  localparam logic [CoordWidth-1:0] Half = 32'h0000_8000;
  localparam logic [CoordWidth-1:0] CMax = 32'h7fff_ffff;
  localparam logic [CoordWidth-1:0] CMin = 32'h8000_0000;
  localparam longint CoordMax = (longint'(1) <<< (CoordWidth - 1)) - 1;
  localparam longint CoordMin = -(longint'(1) <<< (CoordWidth - 1));
  localparam logic [127:0] DeltaCap = 128'h1 << 62;

  typedef struct packed {
    op_e                   opcode;
    logic [CoordWidth-1:0] px, py, pz;
    logic [CoordWidth-1:0] lox, loy, loz;
    logic [CoordWidth-1:0] hix, hiy, hiz;
    logic [CoordWidth-1:0] off;
  } query_t;

  typedef struct packed {
    logic [CoordWidth-1:0] nx, ny, nz;
    logic                  was_inside;
    face_e                 face;
    logic                  sat;
  } pushout_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [1:0]            opcode_i;
  logic [CoordWidth-1:0] point_x_i, point_y_i, point_z_i;
  logic [CoordWidth-1:0] box_min_x_i, box_min_y_i, box_min_z_i;
  logic [CoordWidth-1:0] box_max_x_i, box_max_y_i, box_max_z_i;
  logic [CoordWidth-1:0] push_offset_i;
  logic                  done_o;
  logic [CoordWidth-1:0] new_x_o, new_y_o, new_z_o;
  logic                  was_inside_o;
  logic [2:0]            face_chosen_o;
  logic                  saturated_o;

  pushout_t pending_results[$];
  pushout_t cur_expect;
  query_t   dir_query[$];
  pushout_t dir_typed[$];
  bit       dir_known[$];

  int mismatches   = 0;
  int results_seen = 0;
  int inside_seen  = 0;
  int sat_seen     = 0;
  int queries_sent = 0;
  int cycle_count  = 0;
  int op_taken[4]  = '{0, 0, 0, 0};

  aabb_point_pushout_unit #(
    .COORD_WIDTH(CoordWidth),
    .FRAC_BITS  (FracBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .box_min_x_i  (box_min_x_i),
    .box_min_y_i  (box_min_y_i),
    .box_min_z_i  (box_min_z_i),
    .box_max_x_i  (box_max_x_i),
    .box_max_y_i  (box_max_y_i),
    .box_max_z_i  (box_max_z_i),
    .push_offset_i(push_offset_i),
    .done_o       (done_o),
    .new_x_o      (new_x_o),
    .new_y_o      (new_y_o),
    .new_z_o      (new_z_o),
    .was_inside_o (was_inside_o),
    .face_chosen_o(face_chosen_o),
    .saturated_o  (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic pushout_t predict_pushout(query_t q);
    longint       pt[NumAxes], lo[NumAxes], hi[NumAxes], face_dist[2*NumAxes];
    longint       ext, off, delta, moved;
    logic [127:0] prod;
    bit           inside_box, xz_only;
    int           best, axis;
    pushout_t     r;
    pt[0] = longint'($signed(q.px));
    pt[1] = longint'($signed(q.py));
    pt[2] = longint'($signed(q.pz));
    lo[0] = longint'($signed(q.lox));
    lo[1] = longint'($signed(q.loy));
    lo[2] = longint'($signed(q.loz));
    hi[0] = longint'($signed(q.hix));
    hi[1] = longint'($signed(q.hiy));
    hi[2] = longint'($signed(q.hiz));
    xz_only = (q.opcode == OP_EXTENT) || (q.opcode == OP_SCALED);
    inside_box = 1'b1;
    for (int i = 0; i < NumAxes; i++) begin
      if (pt[i] < lo[i] || pt[i] > hi[i]) inside_box = 1'b0;
    end
    r.nx = q.px;
    r.ny = q.py;
    r.nz = q.pz;
    r.was_inside = 1'b0;
    r.face = FACE_XMIN;
    r.sat = 1'b0;
    if (inside_box) begin
      best = -1;
      for (int i = 0; i < 2 * NumAxes; i++) begin
        face_dist[i] = (i % 2) ? hi[i/2] - pt[i/2] : pt[i/2] - lo[i/2];
        if (!(xz_only && (i == FACE_YMIN || i == FACE_YMAX)) &&
            (best < 0 || face_dist[i] < face_dist[best])) best = i;
      end
      axis = best / 2;
      ext = hi[axis] - lo[axis];
      off = longint'($signed(q.off));
      case (q.opcode)
        OP_EXTENT: delta = ext;
        OP_OFFSET: delta = off;
        OP_SCALED: begin
          prod = (128'(ext) * 128'(off < 0 ? -off : off)) >> FracBits;
          if (prod > DeltaCap) prod = DeltaCap;
          delta = off < 0 ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        end
        default: delta = 0;
      endcase
      moved = (best % 2) ? hi[axis] + delta : lo[axis] - delta;
      if (moved > CoordMax) begin
        moved = CoordMax;
        r.sat = 1'b1;
      end else if (moved < CoordMin) begin
        moved = CoordMin;
        r.sat = 1'b1;
      end
      case (axis)
        0:       r.nx = moved[CoordWidth-1:0];
        1:       r.ny = moved[CoordWidth-1:0];
        default: r.nz = moved[CoordWidth-1:0];
      endcase
      r.was_inside = 1'b1;
      r.face = face_e'(best);
    end
    return r;
  endfunction

  function automatic query_t mk_query(op_e op,
                                      logic [CoordWidth-1:0] px, py, pz,
                                      logic [CoordWidth-1:0] lox, loy, loz,
                                      logic [CoordWidth-1:0] hix, hiy, hiz,
                                      logic [CoordWidth-1:0] off);
    query_t q;
    q = '{opcode: op, px: px, py: py, pz: pz, lox: lox, loy: loy, loz: loz,
          hix: hix, hiy: hiy, hiz: hiz, off: off};
    return q;
  endfunction

  function automatic pushout_t mk_result(logic [CoordWidth-1:0] nx, ny, nz,
                                         logic was_inside, face_e face, logic sat);
    pushout_t r;
    r = '{nx: nx, ny: ny, nz: nz, was_inside: was_inside, face: face, sat: sat};
    return r;
  endfunction

  task automatic add_case(query_t q, bit known, pushout_t r);
    dir_query.push_back(q);
    dir_known.push_back(known);
    dir_typed.push_back(r);
  endtask

  function automatic logic [CoordWidth-1:0] near_coord();
    return $urandom_range(0, 32'h003f_ffff) - 32'h0020_0000;
  endfunction

  task automatic gen_axis(bit wide, output logic [CoordWidth-1:0] lo, hi, pt);
    logic [CoordWidth-1:0] a, b;
    logic [63:0]           span;
    a = wide ? $urandom : near_coord();
    b = ($urandom_range(0, 19) == 0) ? a : (wide ? $urandom : near_coord());
    if ($signed(a) > $signed(b)) begin
      lo = b;
      hi = a;
    end else begin
      lo = a;
      hi = b;
    end
    span = 64'($signed(hi)) - 64'($signed(lo));
    case ($urandom_range(0, 9))
      0:       pt = lo;
      1:       pt = hi;
      2:       pt = lo + CoordWidth'(span >> 1);
      default: pt = lo + CoordWidth'({$urandom, $urandom} % (span + 1));
    endcase
  endtask

  task automatic gen_query(output query_t q);
    logic [CoordWidth-1:0] lo[NumAxes], hi[NumAxes], pt[NumAxes];
    int                    kind;
    kind = $urandom_range(0, 99);
    q.opcode = op_e'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       q.off = CMin;
      1:       q.off = CMax;
      2, 3:    q.off = $urandom;
      default: q.off = near_coord() >>> 3;
    endcase
    for (int i = 0; i < NumAxes; i++) begin
      if (kind < 15) begin
        lo[i] = $urandom;
        hi[i] = $urandom;
        pt[i] = $urandom;
      end else begin
        gen_axis(kind >= 75, lo[i], hi[i], pt[i]);
      end
    end
    q.px = pt[0];
    q.py = pt[1];
    q.pz = pt[2];
    q.lox = lo[0];
    q.loy = lo[1];
    q.loz = lo[2];
    q.hix = hi[0];
    q.hiy = hi[1];
    q.hiz = hi[2];
  endtask

  task automatic send_query(query_t q, pushout_t want, int gap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i      = q.opcode;
    point_x_i     = q.px;
    point_y_i     = q.py;
    point_z_i     = q.pz;
    box_min_x_i   = q.lox;
    box_min_y_i   = q.loy;
    box_min_z_i   = q.loz;
    box_max_x_i   = q.hix;
    box_max_y_i   = q.hiy;
    box_max_z_i   = q.hiz;
    push_offset_i = q.off;
    cur_expect    = want;
    start_i       = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [CoordWidth-1:0] want,
                             logic [CoordWidth-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    pushout_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got x=%h y=%h z=%h",
                   $time, new_x_o, new_y_o, new_z_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("new_x", want.nx, new_x_o);
          check_field("new_y", want.ny, new_y_o);
          check_field("new_z", want.nz, new_z_o);
          check_field("was_inside", CoordWidth'(want.was_inside),
                      CoordWidth'(was_inside_o));
          check_field("face_chosen", CoordWidth'(want.face), CoordWidth'(face_chosen_o));
          check_field("saturated", CoordWidth'(want.sat), CoordWidth'(saturated_o));
          results_seen++;
          if (want.was_inside) inside_seen++;
          if (want.sat) sat_seen++;
        end
      end
      if (start_i && !busy_o) begin
        pending_results.push_back(cur_expect);
        op_taken[opcode_i]++;
        queries_sent++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timed out after %0d cycles, %0d results pending", $time, cycle_count,
               pending_results.size());
      $display("aabb_point_pushout_unit test failed");
      $finish;
    end
  end

  initial begin
    query_t q;
    bit     gappy;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    opcode_i      = OP_FACE;
    point_x_i     = '0;
    point_y_i     = '0;
    point_z_i     = '0;
    box_min_x_i   = '0;
    box_min_y_i   = '0;
    box_min_z_i   = '0;
    box_max_x_i   = '0;
    box_max_y_i   = '0;
    box_max_z_i   = '0;
    push_offset_i = '0;
    cur_expect    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    add_case(mk_query(OP_FACE, 5 * One, 0, 0, -One, -One, -One, One, One, One, 0),
             1, mk_result(5 * One, 0, 0, 0, FACE_XMIN, 0));
    add_case(mk_query(OP_OFFSET, 0, 0, 0, One, -One, -One, -One, One, One, One),
             1, mk_result(0, 0, 0, 0, FACE_XMIN, 0));
    add_case(mk_query(OP_FACE, 0, 0, 0, -One, -One, -One, One, One, One, 0),
             1, mk_result(-One, 0, 0, 1, FACE_XMIN, 0));
    add_case(mk_query(OP_FACE, One, 0, 0, -One, -One, -One, One, One, One, 0),
             1, mk_result(One, 0, 0, 1, FACE_XMAX, 0));
    add_case(mk_query(OP_FACE, 0, -Half, 0, -One, -One, -One, One, One, One, 0),
             1, mk_result(0, -One, 0, 1, FACE_YMIN, 0));
    add_case(mk_query(OP_FACE, 0, Half, 0, -One, -One, -One, One, One, One, 0),
             1, mk_result(0, One, 0, 1, FACE_YMAX, 0));
    add_case(mk_query(OP_FACE, 0, 0, -Half, -One, -One, -One, One, One, One, 0),
             1, mk_result(0, 0, -One, 1, FACE_ZMIN, 0));
    add_case(mk_query(OP_FACE, 0, 0, Half, -One, -One, -One, One, One, One, 0),
             1, mk_result(0, 0, One, 1, FACE_ZMAX, 0));
    add_case(mk_query(OP_EXTENT, 0, -Half, 0, -One, -One, -One, One, One, One, 0),
             1, mk_result(-(3 * One), -Half, 0, 1, FACE_XMIN, 0));
    add_case(mk_query(OP_EXTENT, 0, 0, Half, -One, -One, -One, One, One, One, 0),
             1, mk_result(0, 0, 3 * One, 1, FACE_ZMAX, 0));
    add_case(mk_query(OP_OFFSET, Half, 0, 0, -One, -One, -One, One, One, One, One),
             1, mk_result(2 * One, 0, 0, 1, FACE_XMAX, 0));
    add_case(mk_query(OP_OFFSET, Half, 0, 0, -One, -One, -One, One, One, One, -Half),
             1, mk_result(Half, 0, 0, 1, FACE_XMAX, 0));
    add_case(mk_query(OP_SCALED, -Half, 0, 0, -One, -One, -One, One, One, One, Half),
             1, mk_result(-(2 * One), 0, 0, 1, FACE_XMIN, 0));
    add_case(mk_query(OP_SCALED, 0, Half, 0, -One, -One, -One, One, One, One, One),
             1, mk_result(-(3 * One), Half, 0, 1, FACE_XMIN, 0));
    add_case(mk_query(OP_OFFSET, CMax, 0, 0, 0, 0, 0, CMax, 0, 0, One),
             1, mk_result(CMax, 0, 0, 1, FACE_XMAX, 1));
    add_case(mk_query(OP_EXTENT, CMin, 0, 0, CMin, 0, 0, CMax, 0, 0, 0),
             1, mk_result(CMin, 0, 0, 1, FACE_XMIN, 1));
    add_case(mk_query(OP_FACE, CMin, CMin, CMin, CMin, CMin, CMin, CMax, CMax, CMax, 0),
             1, mk_result(CMin, CMin, CMin, 1, FACE_XMIN, 0));
    add_case(mk_query(OP_EXTENT, 0, 2 * One, 0, -One, -One, -One, One, One, One, 0),
             1, mk_result(0, 2 * One, 0, 0, FACE_XMIN, 0));
    add_case(mk_query(OP_SCALED, One, One, One, One, One, One, One, One, One, CMax),
             1, mk_result(One, One, One, 1, FACE_XMIN, 0));
    add_case(mk_query(OP_SCALED, CMin, 0, 0, CMin, 0, 0, CMax, 0, 0, CMin), 0, '0);
    add_case(mk_query(OP_SCALED, CMax, 0, 0, CMin, 0, 0, CMax, 0, 0, CMax), 0, '0);
    add_case(mk_query(OP_OFFSET, -One, 0, 0, -One, -One, -One, One, One, One, CMin), 0, '0);
    add_case(mk_query(OP_OFFSET, CMin, 0, 0, CMin, 0, 0, 0, 0, 0, CMax), 0, '0);
    add_case(mk_query(OP_SCALED, Half, 0, 0, -One, -One, -One, One, One, One, -One), 0, '0);

    for (int k = 0; k < dir_query.size(); k++) begin
      send_query(dir_query[k], dir_known[k] ? dir_typed[k] : predict_pushout(dir_query[k]),
                 (k % 3 == 0) ? $urandom_range(0, 16) : 0);
    end

    gappy = 1'b0;
    for (int k = 0; k < RandomItems; k++) begin
      if (k % 40 == 0) gappy = $urandom_range(0, 2) != 0;
      gen_query(q);
      send_query(q, predict_pushout(q), gappy ? $urandom_range(0, 16) : 0);
    end
    start_i = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 4) @(posedge clk_i);

    $display("Sent %0d queries (%0d directed), modes 0..3 taken %0d/%0d/%0d/%0d times.",
             queries_sent, dir_query.size(), op_taken[0], op_taken[1], op_taken[2],
             op_taken[3]);
    $display("Checked %0d results: %0d pushed out of the box, %0d clipped, %0d mismatches.",
             results_seen, inside_seen, sat_seen, mismatches);
    if (mismatches == 0) begin
      $display("aabb_point_pushout_unit test passed");
    end else begin
      $display("aabb_point_pushout_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/aabb_pkg.sv
hdl/aabb_point_pushout_unit.sv
dv/tb_aabb_point_pushout_unit.sv
